FILE: rtl/core/v3n_pkg.sv
// ---------------------------------------------------------------------------
// v3n_pkg: shared types and constants for the vector normalizer
// Word layouts, datapath widths and pipeline depths.
// ---------------------------------------------------------------------------
package v3n_pkg;

  localparam int IN_W          = 32;
  localparam int OUT_FRAC_BITS = 30;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;

  // Squares and their sum
  localparam int SQ_W  = 2 * IN_W;
  localparam int SUM_W = SQ_W + 2;

  // Long division sq * 4^(F+1) / sum, one quotient bit per stage
  localparam int DIV_STEPS = 2 * OUT_FRAC_BITS + 3;
  localparam int QUO_W     = DIV_STEPS;
  localparam int REM_W     = SUM_W + 1;

  // Integer square root of the quotient, one root bit per stage
  localparam int SQRT_STEPS = (QUO_W + 1) / 2;
  localparam int SQIN_W     = 2 * SQRT_STEPS;
  localparam int SREM_W     = SQRT_STEPS + 2;

  // Lane depth, and input-to-strobe latency of the whole block
  localparam int LANE_LAT  = DIV_STEPS + SQRT_STEPS;
  localparam int TOTAL_LAT = LANE_LAT + 3;

  localparam logic signed [OUT_W-1:0] UNIT_ONE = OUT_W'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic signed [IN_W-1:0] comp_x;
    logic signed [IN_W-1:0] comp_y;
    logic signed [IN_W-1:0] comp_z;
  } v3n_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    zero_vector;
  } v3n_out_t;

endpackage

FILE: rtl/core/vector3_normalize.sv
// ---------------------------------------------------------------------------
// vector3_normalize: three-vector normalization to signed Q2.30
// Each start gives one result strobed by out_valid; one word per cycle.
// Depth is set by the per-lane divider (63 stages) and square root (32).
// busy stays low: a new word is taken every cycle, results are never held.
// Reset (rst_n, synchronous, active low) clears only the valid pipeline.
// ---------------------------------------------------------------------------
module vector3_normalize import v3n_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  v3n_in_t  in_data,
  output logic     out_valid,
  output v3n_out_t out_data
);

  logic                 accept;
  logic [TOTAL_LAT-1:0] vld_r, vld_nxt;

  // Stage 1: per-component squares
  logic [SQ_W-1:0] sq_r [3];
  logic            neg_r [3];

  // Stage 2: merge squares into the sum, align per-lane data
  logic [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]  sq_d_r [3];
  logic             neg_d_r [3];
  logic             zero_r;

  logic [LANE_LAT-1:0]     zpipe_r;
  logic signed [OUT_W-1:0] lane_unit [3];
  v3n_out_t                out_r, out_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  v3n_square u_sq_x (.clk(clk), .comp(in_data.comp_x), .sq_r(sq_r[0]), .neg_r(neg_r[0]));
  v3n_square u_sq_y (.clk(clk), .comp(in_data.comp_y), .sq_r(sq_r[1]), .neg_r(neg_r[1]));
  v3n_square u_sq_z (.clk(clk), .comp(in_data.comp_z), .sq_r(sq_r[2]), .neg_r(neg_r[2]));

  always_ff @(posedge clk) begin
    sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    zero_r <= (sq_r[0] == '0) && (sq_r[1] == '0) && (sq_r[2] == '0);
    for (int i = 0; i < 3; i++) begin
      sq_d_r[i]  <= sq_r[i];
      neg_d_r[i] <= neg_r[i];
    end
  end

  // One lane per component, all sharing the sum
  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3n_unit u_unit (
      .clk  (clk),
      .sq   (sq_d_r[i]),
      .sum  (sum_r),
      .neg  (neg_d_r[i]),
      .unit (lane_unit[i])
    );
  end

  // Carry the zero flag alongside the lanes
  always_ff @(posedge clk) begin
    zpipe_r <= {zpipe_r[LANE_LAT-2:0], zero_r};
  end

  // Output stage: force zero components for a zero vector
  always_comb begin
    out_nxt.zero_vector = zpipe_r[LANE_LAT-1];
    out_nxt.unit_x      = zpipe_r[LANE_LAT-1] ? '0 : lane_unit[0];
    out_nxt.unit_y      = zpipe_r[LANE_LAT-1] ? '0 : lane_unit[1];
    out_nxt.unit_z      = zpipe_r[LANE_LAT-1] ? '0 : lane_unit[2];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Valid tracking: advance one position per cycle
  assign vld_nxt = {vld_r[TOTAL_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[TOTAL_LAT-1];
  assign out_data  = out_r;

  // Every strobe traces back to an accepted input word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, TOTAL_LAT))
    else $error("result without matching input word");

  // Zero vector gives all-zero components
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_vector) |->
      (out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0))
    else $error("zero vector with nonzero components");

  // Unit components stay within [-1.0, 1.0]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.unit_x <= UNIT_ONE && out_data.unit_x >= -UNIT_ONE &&
       out_data.unit_y <= UNIT_ONE && out_data.unit_y >= -UNIT_ONE &&
       out_data.unit_z <= UNIT_ONE && out_data.unit_z >= -UNIT_ONE))
    else $error("unit component out of range");

endmodule

FILE: rtl/core/v3n_square.sv
// ---------------------------------------------------------------------------
// v3n_square: magnitude and square of one component
// Registers the exact square and the sign of a signed component.
// ---------------------------------------------------------------------------
module v3n_square import v3n_pkg::*; (
  input  logic                   clk,
  input  logic signed [IN_W-1:0] comp,
  output logic [SQ_W-1:0]        sq_r,
  output logic                   neg_r
);

  logic [IN_W-1:0] mag;
  logic [SQ_W-1:0] sq_nxt;

  // most negative value maps onto 2^(IN_W-1) unsigned
  assign mag    = comp[IN_W-1] ? (~comp + 1'b1) : comp;
  assign sq_nxt = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk) begin
    sq_r  <= sq_nxt;
    neg_r <= comp[IN_W-1];
  end

endmodule

FILE: rtl/core/v3n_unit.sv
// ---------------------------------------------------------------------------
// v3n_unit: one normalization lane
// Pipelined long division of sq * 4^(F+1) by the sum of squares, then a
// pipelined integer square root; output is the rounded signed component.
// ---------------------------------------------------------------------------
module v3n_unit import v3n_pkg::*; (
  input  logic                    clk,
  input  logic [SQ_W-1:0]         sq,
  input  logic [SUM_W-1:0]        sum,
  input  logic                    neg,
  output logic signed [OUT_W-1:0] unit
);

  logic [REM_W-1:0]      drem_r [DIV_STEPS];
  logic [SUM_W-1:0]      dden_r [DIV_STEPS];
  logic [QUO_W-1:0]      dquo_r [DIV_STEPS];
  logic                  dneg_r [DIV_STEPS];

  logic [SQIN_W-1:0]     sdat_r  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sroot_r [SQRT_STEPS];
  logic [SREM_W-1:0]     srem_r  [SQRT_STEPS];
  logic                  sneg_r  [SQRT_STEPS];

  // Division: first stage takes the top quotient bit straight from sq
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [REM_W-1:0] rin;
    logic [SUM_W-1:0] den;
    logic [QUO_W-1:0] qin;
    logic             nin;
    logic             ge;

    if (s == 0) begin : g_first
      assign rin = REM_W'(sq);
      assign den = sum;
      assign qin = '0;
      assign nin = neg;
    end else begin : g_next
      assign rin = {drem_r[s-1][REM_W-2:0], 1'b0};
      assign den = dden_r[s-1];
      assign qin = dquo_r[s-1];
      assign nin = dneg_r[s-1];
    end

    assign ge = rin >= REM_W'(den);

    always_ff @(posedge clk) begin
      drem_r[s] <= ge ? (rin - REM_W'(den)) : rin;
      dden_r[s] <= den;
      dquo_r[s] <= {qin[QUO_W-2:0], ge};
      dneg_r[s] <= nin;
    end
  end

  // Square root: two radicand bits per stage
  for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_sqrt
    logic [SQIN_W-1:0]     din;
    logic [SQRT_STEPS-1:0] root_in;
    logic [SREM_W-1:0]     rem_in;
    logic                  nin;
    logic [SREM_W+1:0]     rcat;
    logic [SREM_W+1:0]     trial;
    logic                  ge;

    if (t == 0) begin : g_first
      assign din     = SQIN_W'(dquo_r[DIV_STEPS-1]);
      assign root_in = '0;
      assign rem_in  = '0;
      assign nin     = dneg_r[DIV_STEPS-1];
    end else begin : g_next
      assign din     = sdat_r[t-1];
      assign root_in = sroot_r[t-1];
      assign rem_in  = srem_r[t-1];
      assign nin     = sneg_r[t-1];
    end

    assign rcat  = {rem_in, din[SQIN_W-1 -: 2]};
    assign trial = (SREM_W+2)'({root_in, 2'b01});
    assign ge    = rcat >= trial;

    always_ff @(posedge clk) begin
      srem_r[t]  <= ge ? SREM_W'(rcat - trial) : SREM_W'(rcat);
      sroot_r[t] <= {root_in[SQRT_STEPS-2:0], ge};
      sdat_r[t]  <= {din[SQIN_W-3:0], 2'b00};
      sneg_r[t]  <= nin;
    end
  end

  // Largest q with 2q-1 <= root is (root+1)/2
  logic [SQRT_STEPS:0] qsum;
  logic [OUT_W-1:0]    qmag;

  assign qsum = (SQRT_STEPS+1)'(sroot_r[SQRT_STEPS-1]) + 1'b1;
  assign qmag = OUT_W'(qsum[SQRT_STEPS:1]);
  assign unit = sneg_r[SQRT_STEPS-1] ? $signed(~qmag + 1'b1) : $signed(qmag);

endmodule
